// ----- rtl/wcg_pkg.sv -----
// Shared constants and types for the Q15 window coefficient generator.
package wcg_pkg;

    localparam int IDX_W   = 12;
    localparam int LEN_W   = 13;
    localparam int KIND_W  = 3;
    localparam int COEF_W  = 15;
    localparam int PHASE_W = 16;
    localparam int QUOT_W  = PHASE_W + 1;
    localparam int REM_W   = IDX_W;
    localparam int CFG_A_W = 1;

    localparam logic [LEN_W-1:0] MAX_LEN   = 13'd4096;
    localparam logic [LEN_W-1:0] LEN_RESET = 13'd256;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_HANN     = 3'd0;
    localparam t_kind KIND_HAMMING  = 3'd1;
    localparam t_kind KIND_BLACKMAN = 3'd2;
    localparam t_kind KIND_BARTLETT = 3'd3;
    localparam t_kind KIND_RECT     = 3'd4;
    localparam t_kind KIND_NONE     = 3'd5;

    localparam logic [CFG_A_W-1:0] REG_KIND   = 1'd0;
    localparam logic [CFG_A_W-1:0] REG_LENGTH = 1'd1;

    localparam logic [COEF_W-1:0] COEF_FULL = 15'h7FFF;

    // CORDIC datapath
    localparam int CORDIC_ITERS = 24;
    localparam int XY_W  = 34;
    localparam int Z_W   = 33;
    localparam int ANG_W = 31;
    localparam logic [ANG_W-1:0] HALFPI_Q30 = 31'd1686629713;
    localparam logic signed [XY_W-1:0] CORDIC_K = 34'sd652032874;

    localparam logic signed [Z_W-1:0] ATAN_Q30 [CORDIC_ITERS] = '{
        33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
        33'sd67021687,  33'sd33543516,  33'sd16775851,  33'sd8388437,
        33'sd4194283,   33'sd2097149,   33'sd1048576,   33'sd524288,
        33'sd262144,    33'sd131072,    33'sd65536,     33'sd32768,
        33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,
        33'sd1024,      33'sd512,       33'sd256,       33'sd128
    };

    // Window weights, Q30
    localparam logic signed [31:0] HALF_Q30 = 32'sd536870912;
    localparam logic signed [31:0] HAM_A0   = 32'sd579820585;
    localparam logic signed [31:0] HAM_A1   = 32'sd493921239;
    localparam logic signed [31:0] BLK_B0   = 32'sd450971566;
    localparam logic signed [31:0] BLK_B2   = 32'sd85899346;
    localparam logic [30:0]        ONE_Q30  = 31'd1073741824;

    // Bartlett divider
    localparam int BQ_W = COEF_W;
    localparam int BD_W = REM_W + BQ_W;
    localparam logic [BQ_W:0] TWO_FULL = 16'd65534;

    // Latencies
    localparam int PH_LAT  = QUOT_W;
    localparam int COS_LAT = CORDIC_ITERS + 2;
    localparam int LAT     = PH_LAT + COS_LAT + 3;

endpackage

// ----- rtl/window_coefficient_generator_q15.sv -----
// Top level: Q15 window coefficient generator (Hann, Hamming, Blackman, Bartlett, rectangular).
//
//  channel | ports                                    | transfer
//  --------+------------------------------------------+------------------------------
//  index   | i_start, o_busy, i_sample_index          | i_start high, o_busy low
//  result  | o_valid, o_coefficient, o_index_invalid  | o_valid high, one cycle
//  config  | i_cfg_we, i_cfg_addr, i_cfg_data         | i_cfg_we high
//
//  One index per cycle.
//  Pipeline: 17 divider stages for the phase, 26 CORDIC stages, 3 weighting stages.
//  o_busy is always low. Synchronous reset clears valid bits; config resets to rectangular, length 256.
//  Results cannot be stalled; the pipeline advances every cycle.
module window_coefficient_generator_q15
    import wcg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [IDX_W-1:0]   i_sample_index,
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [LEN_W-1:0]   i_cfg_data,
    output logic               o_valid,
    output logic [COEF_W-1:0]  o_coefficient,
    output logic               o_index_invalid
);

    t_kind             r_kind;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  n_eff;
    logic [REM_W-1:0]  dm1;
    logic              accept;

    logic              r_vld [LAT];
    logic              r_inv [LAT-1];

    // Bartlett path
    logic [REM_W-1:0]  half;
    logic [REM_W-1:0]  idx_dist;
    logic [REM_W-1:0]  tri_t;
    logic [REM_W-1:0]  r_bt;
    logic [BD_W-1:0]   r_bd;
    logic [REM_W-1:0]  r_brem [BQ_W];
    logic [BQ_W-1:0]   r_blo  [BQ_W];
    logic [BQ_W-1:0]   r_bq   [BQ_W];
    logic [COEF_W-1:0] r_bc   [LAT-PH_LAT-1];

    // Cosine path
    logic [QUOT_W-1:0]      quot;
    logic [QUOT_W:0]        quot_rnd;
    logic [PHASE_W-1:0]     phase1;
    logic [PHASE_W-1:0]     phase2;
    logic signed [XY_W-1:0] cos1;
    logic signed [XY_W-1:0] cos2;
    logic signed [63:0]     m1;
    logic signed [63:0]     m2;
    logic signed [XY_W-1:0] r_p1;
    logic signed [XY_W-1:0] r_p2;
    logic signed [XY_W+1:0] v;
    logic [30:0]            r_v;
    logic [45:0]            scaled;
    logic [COEF_W-1:0]      coef_sel;
    logic [COEF_W-1:0]      r_coef;
    logic                   r_iv;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_RECT;
            r_len  <= LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_KIND:   r_kind <= i_cfg_data[KIND_W-1:0];
                REG_LENGTH: r_len  <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    assign n_eff = (r_len > MAX_LEN) ? MAX_LEN : r_len;
    assign dm1   = REM_W'(n_eff - 1'b1);

    // Valid and out-of-range flag lines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LAT; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else begin
            r_vld[0] <= accept;
            for (int j = 1; j < LAT; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_inv[0] <= ({1'b0, i_sample_index} >= n_eff);
        for (int j = 1; j < LAT-1; j++) begin
            r_inv[j] <= r_inv[j-1];
        end
    end

    // Bartlett: (2*32767*t) / (N-1), t = h - |i-h|
    assign half     = dm1 >> 1;
    assign idx_dist = (i_sample_index >= half) ? (i_sample_index - half)
                                               : (half - i_sample_index);
    assign tri_t    = (half >= idx_dist) ? (half - idx_dist) : '0;

    always_ff @(posedge i_clk) begin
        r_bt <= tri_t;
        r_bd <= BD_W'(r_bt * TWO_FULL);
    end

    genvar k;
    for (k = 0; k < BQ_W; k++) begin : g_bdiv
        logic [REM_W-1:0] rem_in;
        logic [BQ_W-1:0]  lo_in;
        logic [BQ_W-1:0]  q_in;
        logic [REM_W:0]   s;
        if (k == 0) begin : g_first
            assign rem_in = r_bd[BD_W-1:BQ_W];
            assign lo_in  = r_bd[BQ_W-1:0];
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_brem[k-1];
            assign lo_in  = r_blo[k-1];
            assign q_in   = r_bq[k-1];
        end
        assign s = {rem_in, lo_in[BQ_W-1]};
        always_ff @(posedge i_clk) begin
            r_blo[k] <= {lo_in[BQ_W-2:0], 1'b0};
            if (s >= {1'b0, dm1}) begin
                r_brem[k] <= REM_W'(s - {1'b0, dm1});
                r_bq[k]   <= {q_in[BQ_W-2:0], 1'b1};
            end else begin
                r_brem[k] <= s[REM_W-1:0];
                r_bq[k]   <= {q_in[BQ_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bc[0] <= r_bq[BQ_W-1];
        for (int j = 1; j < LAT-PH_LAT-1; j++) begin
            r_bc[j] <= r_bc[j-1];
        end
    end

    // Phase and cosines
    wcg_phase_div u_phase (
        .i_clk   (i_clk),
        .i_index (i_sample_index),
        .i_len   (n_eff),
        .o_quot  (quot)
    );

    assign quot_rnd = {1'b0, quot} + 1'b1;
    assign phase1   = quot_rnd[PHASE_W:1];
    assign phase2   = {phase1[PHASE_W-2:0], 1'b0};

    wcg_cordic u_cos1 (
        .i_clk   (i_clk),
        .i_phase (phase1),
        .o_cos   (cos1)
    );

    wcg_cordic u_cos2 (
        .i_clk   (i_clk),
        .i_phase (phase2),
        .o_cos   (cos2)
    );

    // Weighting
    assign m1 = 64'(cos1) * 64'(HAM_A1);
    assign m2 = 64'(cos2) * 64'(BLK_B2);

    always_ff @(posedge i_clk) begin
        if (r_kind == KIND_HAMMING) begin
            r_p1 <= XY_W'(m1 >>> 30);
        end else begin
            r_p1 <= cos1 >>> 1;
        end
        r_p2 <= XY_W'(m2 >>> 30);
    end

    always_comb begin
        case (r_kind)
            KIND_HAMMING:  v = (XY_W+2)'(HAM_A0) - (XY_W+2)'(r_p1);
            KIND_BLACKMAN: v = (XY_W+2)'(BLK_B0) - (XY_W+2)'(r_p1) + (XY_W+2)'(r_p2);
            default:       v = (XY_W+2)'(HALF_Q30) - (XY_W+2)'(r_p1);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (v[XY_W+1]) begin
            r_v <= '0;
        end else if (v > (XY_W+2)'(ONE_Q30)) begin
            r_v <= ONE_Q30;
        end else begin
            r_v <= v[30:0];
        end
    end

    assign scaled = {r_v, 15'b0} - 46'(r_v);

    always_comb begin
        case (r_kind) inside
            KIND_HANN, KIND_HAMMING, KIND_BLACKMAN: coef_sel = scaled[44:30];
            KIND_BARTLETT: coef_sel = (n_eff == 13'd1) ? COEF_FULL : r_bc[LAT-PH_LAT-2];
            default:       coef_sel = COEF_FULL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_iv   <= r_inv[LAT-2];
        r_coef <= r_inv[LAT-2] ? '0 : coef_sel;
    end

    assign o_valid         = r_vld[LAT-1];
    assign o_coefficient   = r_coef;
    assign o_index_invalid = r_iv;

    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_index_invalid |-> o_coefficient == '0)
        else $error("out-of-range index with nonzero coefficient");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LAT))
        else $error("result without matching transfer");

    a_rect_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_index_invalid && (r_kind == KIND_RECT || r_kind == KIND_NONE)
        |-> o_coefficient == COEF_FULL)
        else $error("rectangular window not full scale");

endmodule

// ----- rtl/wcg_phase_div.sv -----
// Pipelined restoring divider: floor(i * 2^17 / n) for i < n, one quotient bit per stage.
module wcg_phase_div
    import wcg_pkg::*;
(
    input  logic              i_clk,
    input  logic [IDX_W-1:0]  i_index,
    input  logic [LEN_W-1:0]  i_len,
    output logic [QUOT_W-1:0] o_quot
);

    logic [REM_W-1:0]  r_rem [QUOT_W];
    logic [QUOT_W-1:0] r_q   [QUOT_W];

    genvar k;
    for (k = 0; k < QUOT_W; k++) begin : g_st
        logic [REM_W-1:0]  rem_in;
        logic [QUOT_W-1:0] q_in;
        logic [REM_W:0]    s;
        if (k == 0) begin : g_first
            assign rem_in = i_index;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
        end
        assign s = {rem_in, 1'b0};
        always_ff @(posedge i_clk) begin
            if (s >= i_len) begin
                r_rem[k] <= REM_W'(s - i_len);
                r_q[k]   <= {q_in[QUOT_W-2:0], 1'b1};
            end else begin
                r_rem[k] <= s[REM_W-1:0];
                r_q[k]   <= {q_in[QUOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_q[QUOT_W-1];

endmodule

// ----- rtl/wcg_cordic.sv -----
// Pipelined rotation CORDIC: Q30 cosine of a 16-bit phase.
module wcg_cordic
    import wcg_pkg::*;
(
    input  logic                   i_clk,
    input  logic [PHASE_W-1:0]     i_phase,
    output logic signed [XY_W-1:0] o_cos
);

    logic [ANG_W-1:0]          r_ang;
    logic [1:0]                r_quad [CORDIC_ITERS+1];
    logic signed [XY_W-1:0]    r_x    [CORDIC_ITERS];
    logic signed [XY_W-1:0]    r_y    [CORDIC_ITERS];
    logic signed [Z_W-1:0]     r_z    [CORDIC_ITERS-1];
    logic [ANG_W+PHASE_W-3:0]  ang_prod;
    logic signed [XY_W-1:0]    r_cos;

    assign ang_prod = (ANG_W+PHASE_W-2)'(i_phase[PHASE_W-3:0]) *
                      (ANG_W+PHASE_W-2)'(HALFPI_Q30);

    always_ff @(posedge i_clk) begin
        r_ang     <= ang_prod[ANG_W+PHASE_W-3:PHASE_W-2];
        r_quad[0] <= i_phase[PHASE_W-1:PHASE_W-2];
        for (int j = 1; j <= CORDIC_ITERS; j++) begin
            r_quad[j] <= r_quad[j-1];
        end
    end

    genvar k;
    for (k = 0; k < CORDIC_ITERS; k++) begin : g_it
        logic signed [XY_W-1:0] x_in;
        logic signed [XY_W-1:0] y_in;
        logic signed [Z_W-1:0]  z_in;
        if (k == 0) begin : g_first
            assign x_in = CORDIC_K;
            assign y_in = '0;
            assign z_in = signed'({2'b00, r_ang});
        end else begin : g_next
            assign x_in = r_x[k-1];
            assign y_in = r_y[k-1];
            assign z_in = r_z[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!z_in[Z_W-1]) begin
                r_x[k] <= x_in - (y_in >>> k);
                r_y[k] <= y_in + (x_in >>> k);
            end else begin
                r_x[k] <= x_in + (y_in >>> k);
                r_y[k] <= y_in - (x_in >>> k);
            end
        end
        if (k < CORDIC_ITERS-1) begin : g_z
            always_ff @(posedge i_clk) begin
                if (!z_in[Z_W-1]) begin
                    r_z[k] <= z_in - ATAN_Q30[k];
                end else begin
                    r_z[k] <= z_in + ATAN_Q30[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_quad[CORDIC_ITERS])
            2'd0:    r_cos <= r_x[CORDIC_ITERS-1];
            2'd1:    r_cos <= -r_y[CORDIC_ITERS-1];
            2'd2:    r_cos <= -r_x[CORDIC_ITERS-1];
            default: r_cos <= r_y[CORDIC_ITERS-1];
        endcase
    end

    assign o_cos = r_cos;

endmodule

// ----- verif/window_coefficient_generator_q15_tb.sv -----
// Testbench for the Q15 window coefficient generator: directed and random indexes checked against a predictor.
`timescale 1ns / 100ps

module window_coefficient_generator_q15_tb;
    import wcg_pkg::*;

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic              invalid;
    } t_coef_result;

    localparam longint Q30_ONE    = 64'sd1073741824;
    localparam longint Q30_HALFPI = 64'sd1686629713;
    localparam longint Q30_K      = 64'sd652032874;
    localparam longint W_HAM_A0   = 64'sd579820585;
    localparam longint W_HAM_A1   = 64'sd493921239;
    localparam longint W_BLK_B0   = 64'sd450971566;
    localparam longint W_BLK_B1   = 64'sd536870912;
    localparam longint W_BLK_B2   = 64'sd85899346;

    localparam longint ARCTAN_Q30 [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic [IDX_W-1:0]   i_sample_index = '0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_A_W-1:0] i_cfg_addr = '0;
    logic [LEN_W-1:0]   i_cfg_data = '0;
    logic               o_valid;
    logic [COEF_W-1:0]  o_coefficient;
    logic               o_index_invalid;

    window_coefficient_generator_q15 dut (.*);

    always #5 i_clk = ~i_clk;

    logic [KIND_W-1:0] model_kind = KIND_RECT;
    logic [LEN_W-1:0]  model_len = LEN_RESET;
    logic [IDX_W-1:0]  index_queue [$];
    t_coef_result      coef_expected [$];
    int                sender_idle_pct = 0;
    int                error_count = 0;
    int                sent_count = 0;
    int                checked_count = 0;
    int                invalid_seen = 0;

    function automatic longint cordic_cos(logic [15:0] phase);
        logic [1:0] quad;
        longint r, z, x, y, dx, dy;
        quad = phase[15:14];
        r = phase[13:0];
        z = (r * Q30_HALFPI) >>> 14;
        x = Q30_K;
        y = 0;
        for (int k = 0; k < 24; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ARCTAN_Q30[k];
            end else begin
                x += dx; y -= dy; z += ARCTAN_Q30[k];
            end
        end
        case (quad)
            2'd0: return x;
            2'd1: return -y;
            2'd2: return -x;
            default: return y;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] q30_scale(longint v);
        longint c;
        if (v < 0) v = 0;
        if (v > Q30_ONE) v = Q30_ONE;
        c = (v * 32767) >>> 30;
        return (c > 32767) ? 15'h7FFF : c[14:0];
    endfunction

    function automatic t_coef_result window_value(logic [IDX_W-1:0] idx);
        t_coef_result res;
        longint n, i, q, c, c2, v, h, d, t;
        logic [15:0] phase;
        n = model_len;
        i = idx;
        if (n > 4096) n = 4096;
        res.invalid = 1'b0;
        res.coef = '0;
        if (i >= n) begin
            res.invalid = 1'b1;
            return res;
        end
        q = ((i << 17) / n + 1) >>> 1;
        phase = q[15:0];
        case (model_kind)
            KIND_HANN: begin
                c = cordic_cos(phase);
                v = (Q30_ONE >>> 1) - (((Q30_ONE >>> 1) * c) >>> 30);
                res.coef = q30_scale(v);
            end
            KIND_HAMMING: begin
                c = cordic_cos(phase);
                v = W_HAM_A0 - ((W_HAM_A1 * c) >>> 30);
                res.coef = q30_scale(v);
            end
            KIND_BLACKMAN: begin
                c = cordic_cos(phase);
                c2 = cordic_cos({phase[14:0], 1'b0});
                v = W_BLK_B0 - ((W_BLK_B1 * c) >>> 30) + ((W_BLK_B2 * c2) >>> 30);
                res.coef = q30_scale(v);
            end
            KIND_BARTLETT: begin
                if (n < 2) begin
                    res.coef = COEF_FULL;
                end else begin
                    h = (n - 1) / 2;
                    d = i - h;
                    if (d < 0) d = -d;
                    t = h - d;
                    if (t < 0) t = 0;
                    t = (2 * t * 32767) / (n - 1);
                    res.coef = (t > 32767) ? COEF_FULL : t[14:0];
                end
            end
            default: res.coef = COEF_FULL;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
                 checked_count);
        error_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                coef_expected.push_back(window_value(i_sample_index));
                sent_count++;
            end
            if (i_start && o_busy) begin
                i_start <= 1'b1;
            end else if (index_queue.size() > 0 &&
                         $urandom_range(0, 99) >= sender_idle_pct) begin
                i_start <= 1'b1;
                i_sample_index <= index_queue.pop_front();
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_coef_result want;
        if (i_rst_n && o_valid) begin
            if (coef_expected.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                want = coef_expected.pop_front();
                if (o_coefficient !== want.coef)
                    report_mismatch("coefficient", o_coefficient, want.coef);
                if (o_index_invalid !== want.invalid)
                    report_mismatch("index_invalid", o_index_invalid, want.invalid);
                if (want.invalid) invalid_seen++;
            end
            checked_count++;
        end
    end

    task automatic drain();
        while (index_queue.size() > 0 || i_start || coef_expected.size() > 0)
            @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_A_W-1:0] addr, logic [LEN_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        if (addr == REG_KIND) model_kind = data[KIND_W-1:0];
        else model_len = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic setup(logic [LEN_W-1:0] kind, logic [LEN_W-1:0] len);
        drain();
        write_reg(REG_KIND, kind);
        write_reg(REG_LENGTH, len);
    endtask

    initial begin
        int len, kind;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset config, then the corner settings
        index_queue = '{0, 128, 255, 256, 4095};
        setup(KIND_HANN, 4096);
        index_queue = '{0, 1024, 2048, 4095};
        setup(KIND_BLACKMAN, 16);
        index_queue = '{0, 4, 8, 15, 16};
        setup(KIND_BARTLETT, 1);
        index_queue = '{0, 1};
        setup(KIND_BARTLETT, 8);
        index_queue = '{3, 4, 7};
        setup(KIND_HAMMING, 0);
        index_queue = '{0, 4095};
        setup(7, 8191);
        index_queue = '{0, 4095};
        setup(6, 2);
        index_queue = '{0, 1, 2};

        for (int b = 0; b < 29; b++) begin
            case (b % 4)
                0: len = $urandom_range(2, 64);
                1: len = $urandom_range(2, 4096);
                2: len = (b % 8 == 2) ? 4096 : $urandom_range(0, 8191);
                default: len = $urandom_range(0, 3);
            endcase
            kind = $urandom_range(0, 7);
            setup(kind, len);
            sender_idle_pct = (b < 10) ? 18 : (b < 20) ? 81 : 0;
            for (int k = 0; k < 50; k++) begin
                if (len > 0 && $urandom_range(0, 99) < 80)
                    index_queue.push_back($urandom_range(0, (len > 4096 ? 4096 : len) - 1));
                else
                    index_queue.push_back($urandom_range(0, 4095));
            end
        end
        drain();
        repeat (LAT + 10) @(posedge i_clk);

        $display("Covered %0d index transfers, %0d results checked (%0d out of range),",
                 sent_count, checked_count, invalid_seen);
        $display("over all window kinds incl. codes 6/7 and lengths 0..8191.");
        if (error_count == 0 && coef_expected.size() == 0) begin
            $display("window_coefficient_generator_q15_tb: done, clean");
        end else begin
            $display("window_coefficient_generator_q15_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("window_coefficient_generator_q15_tb: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/wcg_pkg.sv
rtl/wcg_phase_div.sv
rtl/wcg_cordic.sv
rtl/window_coefficient_generator_q15.sv
verif/window_coefficient_generator_q15_tb.sv
